>>> rtl/bsi_pkg.sv
`default_nettype none

package bsi_pkg;

    // Width of an element index and of an element offset.
    localparam int IDX_W = 48;

    // Width of the configuration data and register index.
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    // Quotient bits resolved by one divider stage.
    localparam int DIV_STEP = 4;

    // Stride fields sit at 32-bit slots in the stride registers.
    localparam int STRIDE_SLOT = 32;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM_SIZES = 3'd0,
        CFG_A_INNER   = 3'd1,
        CFG_A_OUTER   = 3'd2,
        CFG_B_INNER   = 3'd3,
        CFG_B_OUTER   = 3'd4
    } cfg_reg_t;

endpackage

`default_nettype wire

>>> rtl/broadcast_strided_index.sv
// Broadcast strided index generator.
// Input channel (in_valid / in_ready, element_index) takes the row-major linear
// index of one output element. The output channel (out_valid / out_ready) returns
// the index echoed in out_index together with the element offsets into
// operands a and b, each modulo 2^48.
// The configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
// the dimension sizes and the stride registers; it is always ready, and is
// only to be written while no item is in flight. Unknown indexes are ignored.
// Throughput is one item per clock while in_ready is high. The pipeline has
// 12*MAX_RANK divider stages (four quotient bits per stage, one 48-bit division
// per dimension), one multiplier stage, MAX_RANK accumulation stages and the
// output register.
// When the receiver stalls, the result holds in the output register and the
// pipeline behind it keeps moving until its last stage is occupied; only
// then does in_ready fall. Reset empties the pipeline, sets every size to 1
// and every stride to 0.
`default_nettype none

module broadcast_strided_index #(
    parameter int MAX_RANK    = 4,
    parameter int DIM_BITS    = 16,
    parameter int STRIDE_BITS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [bsi_pkg::IDX_W-1:0]         element_index,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [bsi_pkg::IDX_W-1:0]              out_index,
    output logic [bsi_pkg::IDX_W-1:0]              a_offset,
    output logic [bsi_pkg::IDX_W-1:0]              b_offset,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bsi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bsi_pkg::CFG_W-1:0]         cfg_data
);

    localparam int IDX_W   = bsi_pkg::IDX_W;
    localparam int CFG_W   = bsi_pkg::CFG_W;
    localparam int STEP    = bsi_pkg::DIV_STEP;
    localparam int STEPS   = IDX_W / STEP;
    localparam int NDIV    = MAX_RANK * STEPS;
    localparam int PROD_W  = DIM_BITS + STRIDE_BITS;

    // Reset value of the size register: every size field that fits is 1.
    function automatic logic [CFG_W-1:0] dim_reset();
        logic [CFG_W-1:0] v;
        v = '0;
        for (int k = 0; k < MAX_RANK; k++) begin
            if ((k + 1) * DIM_BITS <= CFG_W) begin
                v[k * DIM_BITS] = 1'b1;
            end
        end
        return v;
    endfunction

    localparam logic [CFG_W-1:0] DIM_RST = dim_reset();

    // Configuration registers.
    logic [CFG_W-1:0] dim_sizes_reg;
    logic [CFG_W-1:0] a_inner_reg;
    logic [CFG_W-1:0] a_outer_reg;
    logic [CFG_W-1:0] b_inner_reg;
    logic [CFG_W-1:0] b_outer_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_sizes_reg <= DIM_RST;
            a_inner_reg   <= '0;
            a_outer_reg   <= '0;
            b_inner_reg   <= '0;
            b_outer_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bsi_pkg::CFG_DIM_SIZES: dim_sizes_reg <= cfg_data;
                bsi_pkg::CFG_A_INNER:   a_inner_reg   <= cfg_data;
                bsi_pkg::CFG_A_OUTER:   a_outer_reg   <= cfg_data;
                bsi_pkg::CFG_B_INNER:   b_inner_reg   <= cfg_data;
                bsi_pkg::CFG_B_OUTER:   b_outer_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Per-dimension size and strides, decoded from the registers.
    logic [DIM_BITS-1:0]    dim_size [MAX_RANK];
    logic [STRIDE_BITS-1:0] a_stride [MAX_RANK];
    logic [STRIDE_BITS-1:0] b_stride [MAX_RANK];

    for (genvar d = 0; d < MAX_RANK; d++) begin : g_dim
        if ((d + 1) * DIM_BITS <= CFG_W) begin : g_size
            logic [DIM_BITS-1:0] field;
            assign field       = dim_sizes_reg[d * DIM_BITS +: DIM_BITS];
            assign dim_size[d] = (field == '0) ? DIM_BITS'(1) : field;
        end
        else begin : g_unit
            assign dim_size[d] = DIM_BITS'(1);
        end

        if (d < 2) begin : g_inner
            assign a_stride[d] = a_inner_reg[bsi_pkg::STRIDE_SLOT * d +: STRIDE_BITS];
            assign b_stride[d] = b_inner_reg[bsi_pkg::STRIDE_SLOT * d +: STRIDE_BITS];
        end
        else if (d < 4) begin : g_outer
            assign a_stride[d] =
                a_outer_reg[bsi_pkg::STRIDE_SLOT * (d - 2) +: STRIDE_BITS];
            assign b_stride[d] =
                b_outer_reg[bsi_pkg::STRIDE_SLOT * (d - 2) +: STRIDE_BITS];
        end
        else begin : g_none
            assign a_stride[d] = '0;
            assign b_stride[d] = '0;
        end
    end

    // Pipeline advance: the whole chain moves unless its last stage holds an
    // item that the output register cannot take.
    logic out_valid_reg;
    logic out_load;
    logic adv;
    logic ad_v_reg [MAX_RANK];

    assign out_load = !out_valid_reg || out_ready;
    assign adv      = out_load || !ad_v_reg[MAX_RANK-1];
    assign in_ready = adv;

    // Divider stages: each resolves four quotient bits of one dimension.
    logic                v_reg     [NDIV];
    logic [IDX_W-1:0]    idx_reg   [NDIV];
    logic [IDX_W-1:0]    work_reg  [NDIV];
    logic [DIM_BITS-1:0] rem_reg   [NDIV];
    logic [DIM_BITS-1:0] coord_reg [NDIV][MAX_RANK];

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        localparam int D = g / STEPS;
        localparam int T = g % STEPS;

        logic                src_v;
        logic [IDX_W-1:0]    src_idx;
        logic [IDX_W-1:0]    src_work;
        logic [DIM_BITS-1:0] src_rem;
        logic [DIM_BITS-1:0] src_coord [MAX_RANK];
        logic [IDX_W-1:0]    work_next;
        logic [DIM_BITS-1:0] rem_next;
        logic [DIM_BITS-1:0] coord_next [MAX_RANK];

        if (g == 0) begin : g_src_in
            assign src_v    = in_valid;
            assign src_idx  = element_index;
            assign src_work = element_index;
            assign src_rem  = '0;
            for (genvar k = 0; k < MAX_RANK; k++) begin : g_c
                assign src_coord[k] = '0;
            end
        end
        else begin : g_src_stage
            assign src_v    = v_reg[g-1];
            assign src_idx  = idx_reg[g-1];
            assign src_work = work_reg[g-1];
            assign src_rem  = rem_reg[g-1];
            for (genvar k = 0; k < MAX_RANK; k++) begin : g_c
                assign src_coord[k] = coord_reg[g-1][k];
            end
        end

        // Restoring division steps; a new dimension starts from remainder 0.
        always_comb
        begin
            logic [DIM_BITS:0] trial;
            logic [DIM_BITS:0] divisor;
            work_next = src_work;
            rem_next  = (T == 0) ? '0 : src_rem;
            divisor   = {1'b0, dim_size[D]};
            for (int j = 0; j < STEP; j++) begin
                trial     = {rem_next, work_next[IDX_W-1]};
                work_next = {work_next[IDX_W-2:0], 1'b0};
                if (trial >= divisor)
                begin
                    trial        = trial - divisor;
                    work_next[0] = 1'b1;
                end
                rem_next = trial[DIM_BITS-1:0];
            end
            for (int k = 0; k < MAX_RANK; k++) begin
                coord_next[k] = src_coord[k];
            end
            if (T == STEPS - 1)
            begin
                coord_next[D] = rem_next;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[g] <= src_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv && src_v)
            begin
                idx_reg[g]  <= src_idx;
                work_reg[g] <= work_next;
                rem_reg[g]  <= rem_next;
                for (int k = 0; k < MAX_RANK; k++) begin
                    coord_reg[g][k] <= coord_next[k];
                end
            end
        end
    end

    // Multiplier stage: coordinate times stride for every dimension.
    logic             mul_v_reg;
    logic [IDX_W-1:0] mul_idx_reg;
    logic [IDX_W-1:0] pa_reg [MAX_RANK];
    logic [IDX_W-1:0] pb_reg [MAX_RANK];
    logic [PROD_W-1:0] pa_next [MAX_RANK];
    logic [PROD_W-1:0] pb_next [MAX_RANK];

    for (genvar k = 0; k < MAX_RANK; k++) begin : g_mul
        assign pa_next[k] = PROD_W'(coord_reg[NDIV-1][k]) * PROD_W'(a_stride[k]);
        assign pb_next[k] = PROD_W'(coord_reg[NDIV-1][k]) * PROD_W'(b_stride[k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            mul_v_reg <= v_reg[NDIV-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && v_reg[NDIV-1])
        begin
            mul_idx_reg <= idx_reg[NDIV-1];
            for (int k = 0; k < MAX_RANK; k++) begin
                pa_reg[k] <= IDX_W'(pa_next[k]);
                pb_reg[k] <= IDX_W'(pb_next[k]);
            end
        end
    end

    // Accumulation stages: stage k adds the product of dimension k.
    logic [IDX_W-1:0] ad_idx_reg [MAX_RANK];
    logic [IDX_W-1:0] acc_a_reg  [MAX_RANK];
    logic [IDX_W-1:0] acc_b_reg  [MAX_RANK];
    logic [IDX_W-1:0] ad_pa_reg  [MAX_RANK][MAX_RANK];
    logic [IDX_W-1:0] ad_pb_reg  [MAX_RANK][MAX_RANK];

    for (genvar s = 0; s < MAX_RANK; s++) begin : g_add
        logic             src_v;
        logic [IDX_W-1:0] src_idx;
        logic [IDX_W-1:0] src_a;
        logic [IDX_W-1:0] src_b;
        logic [IDX_W-1:0] src_pa [MAX_RANK];
        logic [IDX_W-1:0] src_pb [MAX_RANK];

        if (s == 0) begin : g_src_mul
            assign src_v   = mul_v_reg;
            assign src_idx = mul_idx_reg;
            assign src_a   = '0;
            assign src_b   = '0;
            for (genvar k = 0; k < MAX_RANK; k++) begin : g_p
                assign src_pa[k] = pa_reg[k];
                assign src_pb[k] = pb_reg[k];
            end
        end
        else begin : g_src_add
            assign src_v   = ad_v_reg[s-1];
            assign src_idx = ad_idx_reg[s-1];
            assign src_a   = acc_a_reg[s-1];
            assign src_b   = acc_b_reg[s-1];
            for (genvar k = 0; k < MAX_RANK; k++) begin : g_p
                assign src_pa[k] = ad_pa_reg[s-1][k];
                assign src_pb[k] = ad_pb_reg[s-1][k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ad_v_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                ad_v_reg[s] <= src_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv && src_v)
            begin
                ad_idx_reg[s] <= src_idx;
                acc_a_reg[s]  <= src_a + src_pa[s];
                acc_b_reg[s]  <= src_b + src_pb[s];
                for (int k = 0; k < MAX_RANK; k++) begin
                    ad_pa_reg[s][k] <= src_pa[k];
                    ad_pb_reg[s][k] <= src_pb[k];
                end
            end
        end
    end

    // Output register; it holds its item while the receiver stalls.
    logic [IDX_W-1:0] out_index_reg;
    logic [IDX_W-1:0] a_offset_reg;
    logic [IDX_W-1:0] b_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= ad_v_reg[MAX_RANK-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && ad_v_reg[MAX_RANK-1])
        begin
            out_index_reg <= ad_idx_reg[MAX_RANK-1];
            a_offset_reg  <= acc_a_reg[MAX_RANK-1];
            b_offset_reg  <= acc_b_reg[MAX_RANK-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign a_offset  = a_offset_reg;
    assign b_offset  = b_offset_reg;

endmodule

`default_nettype wire
